// ===== rtl/core/assert_macros.svh =====
// assertion macros shared by the stack rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// property must hold at every rising clock edge out of reset
`define SWDV_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// condition must never be seen out of reset
`define SWDV_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define SWDV_ASSERT(lbl, clk, rstn, prop, msg)
`define SWDV_NEVER(lbl, clk, rstn, cond, msg)
`endif

`endif

// ===== rtl/core/swdv_pkg.sv =====
// shared widths, codes and types of the stack with delete-by-value
`default_nettype none

package swdv_pkg;

  localparam int DATA_W     = 32;
  localparam int OP_W       = 2;
  localparam int ST_W       = 2;
  localparam int CNT_OUT_W  = 7;
  localparam int DEPTH_DEF  = 64;

  // operation codes
  localparam logic [OP_W-1:0] OP_PUSH   = 2'd0;
  localparam logic [OP_W-1:0] OP_POP    = 2'd1;
  localparam logic [OP_W-1:0] OP_PEEK   = 2'd2;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd3;

  // status codes
  localparam logic [ST_W-1:0] ST_OK        = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY     = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL      = 2'd2;
  localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd3;

  // one finished result
  typedef struct packed {
    logic signed [DATA_W-1:0] read_value;
    logic [ST_W-1:0]          status;
    logic                     is_empty;
    logic [CNT_OUT_W-1:0]     entry_count;
  } swdv_res_t;

  // sequencer status toward the handshake logic
  typedef struct packed {
    logic ready;
    logic done;
  } swdv_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/swdv_ctrl.sv =====
// entry memory, shared compare unit and operation sequencer
`default_nettype none

module swdv_ctrl #(
  parameter int DEPTH = swdv_pkg::DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic [swdv_pkg::OP_W-1:0]          op,
  input  logic signed [swdv_pkg::DATA_W-1:0] value,
  input  logic                               res_take,
  output swdv_pkg::swdv_stat_t               stat,
  output swdv_pkg::swdv_res_t                res
);
  import swdv_pkg::*;

  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int EXT_W = (CW > CNT_OUT_W) ? CW : CNT_OUT_W;

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_SCMP = 3'd3;
  localparam logic [2:0] S_SHW  = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0]               state_r, state_nxt;
  logic [CW-1:0]            cnt_r, cnt_nxt;
  logic [AW-1:0]            idx_r, idx_nxt;
  logic [OP_W-1:0]          op_r, op_nxt;
  logic signed [DATA_W-1:0] val_r, val_nxt;
  logic signed [DATA_W-1:0] rdv_r, rdv_nxt;
  logic [ST_W-1:0]          st_r, st_nxt;

  logic signed [DATA_W-1:0] mem [DEPTH];
  logic signed [DATA_W-1:0] rd_data_r;
  logic [AW-1:0]            rd_addr;
  logic                     wr_en;
  logic [AW-1:0]            wr_addr;
  logic signed [DATA_W-1:0] wr_data;

  logic [AW-1:0]            top_idx;
  logic [AW-1:0]            idx_inc;
  logic                     full;
  logic                     empty;
  logic                     match;
  logic [EXT_W-1:0]         cnt_ext;

  assign top_idx = AW'(cnt_r - 1'b1);
  assign idx_inc = idx_r + 1'b1;
  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  // shared compare unit
  assign match   = (rd_data_r == val_r);
  assign cnt_ext = EXT_W'(cnt_r);

  // entry memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    idx_nxt   = idx_r;
    op_nxt    = op_r;
    val_nxt   = val_r;
    rdv_nxt   = rdv_r;
    st_nxt    = st_r;
    rd_addr   = idx_r;
    wr_en     = 1'b0;
    wr_addr   = idx_r;
    wr_data   = val_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          op_nxt    = op;
          val_nxt   = value;
          rdv_nxt   = '0;
          st_nxt    = ST_OK;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        case (op_r)
          OP_PUSH: begin
            if (full) begin
              st_nxt = ST_FULL;
            end else begin
              wr_en   = 1'b1;
              wr_addr = AW'(cnt_r);
              wr_data = val_r;
              cnt_nxt = cnt_r + 1'b1;
            end
            state_nxt = S_DONE;
          end
          OP_POP, OP_PEEK: begin
            if (empty) begin
              st_nxt    = ST_EMPTY;
              rdv_nxt   = (op_r == OP_PEEK) ? '1 : '0;
              state_nxt = S_DONE;
            end else begin
              rd_addr   = top_idx;
              state_nxt = S_RD;
            end
          end
          default: begin
            if (empty) begin
              st_nxt    = ST_EMPTY;
              state_nxt = S_DONE;
            end else begin
              idx_nxt   = top_idx;
              rd_addr   = top_idx;
              state_nxt = S_SCMP;
            end
          end
        endcase
      end
      // top entry arrives for pop or peek
      S_RD: begin
        rdv_nxt = rd_data_r;
        if (op_r == OP_POP) begin
          cnt_nxt = cnt_r - 1'b1;
        end
        state_nxt = S_DONE;
      end
      // search downward, one entry per cycle
      S_SCMP: begin
        if (match) begin
          if (idx_r == top_idx) begin
            cnt_nxt   = cnt_r - 1'b1;
            state_nxt = S_DONE;
          end else begin
            rd_addr   = idx_inc;
            state_nxt = S_SHW;
          end
        end else if (idx_r == '0) begin
          st_nxt    = ST_NOT_FOUND;
          state_nxt = S_DONE;
        end else begin
          idx_nxt = idx_r - 1'b1;
          rd_addr = idx_r - 1'b1;
        end
      end
      // close the gap, one entry moved down per cycle
      S_SHW: begin
        wr_en   = 1'b1;
        wr_addr = idx_r;
        wr_data = rd_data_r;
        idx_nxt = idx_inc;
        if (idx_inc == top_idx) begin
          cnt_nxt   = cnt_r - 1'b1;
          state_nxt = S_DONE;
        end else begin
          rd_addr = idx_inc + 1'b1;
        end
      end
      S_DONE: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // transaction payload registers
  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    op_r  <= op_nxt;
    val_r <= val_nxt;
    rdv_r <= rdv_nxt;
    st_r  <= st_nxt;
  end

  // status and result toward the handshake logic
  assign stat.ready       = (state_r == S_IDLE);
  assign stat.done        = (state_r == S_DONE);
  assign res.read_value   = rdv_r;
  assign res.status       = st_r;
  assign res.is_empty     = empty;
  assign res.entry_count  = cnt_ext[CNT_OUT_W-1:0];

  `include "assert_macros.svh"

  `SWDV_ASSERT(a_start_idle, clk, rst_n, start |-> (state_r == S_IDLE), "start while busy")
  `SWDV_NEVER(a_cnt_range, clk, rst_n, cnt_r > CW'(DEPTH), "entry count beyond depth")
  `SWDV_ASSERT(a_push_cnt, clk, rst_n, (state_r == S_EXEC && op_r == OP_PUSH && !full) |=> (cnt_r == $past(cnt_r) + 1'b1), "push did not grow count")
  `SWDV_ASSERT(a_shift_range, clk, rst_n, (state_r == S_SHW) |-> (CW'(idx_r) + 1'b1 < cnt_r), "shift beyond top")

endmodule

`default_nettype wire

// ===== rtl/core/stack_with_delete_by_value.sv =====
// stack with delete-by-value: a push passes through the EXEC state, a pop or peek through EXEC
// and RD, before DONE; delete scans from the top one entry per cycle through one compare unit,
// then moves entries down one per cycle over the single memory write port
// one transaction at a time; in_stall stays high until the result is registered
// synchronous active-low reset empties the stack; entry memory is not cleared
`default_nettype none

module stack_with_delete_by_value #(
  parameter int DEPTH = swdv_pkg::DEPTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [swdv_pkg::OP_W-1:0]             in_opcode,
  input  logic signed [swdv_pkg::DATA_W-1:0]    in_value,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [swdv_pkg::DATA_W-1:0]    out_read_value,
  output logic [swdv_pkg::ST_W-1:0]             out_status,
  output logic                                  out_is_empty,
  output logic [swdv_pkg::CNT_OUT_W-1:0]        out_entry_count
);
  import swdv_pkg::*;

  swdv_stat_t stat;
  swdv_res_t  res;
  swdv_res_t  out_res_r;
  logic       out_valid_r;
  logic       start;
  logic       res_take;

  // input transaction handshake
  assign in_stall = !stat.ready;
  assign start    = in_valid && stat.ready;

  swdv_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .op       (in_opcode),
    .value    (in_value),
    .res_take (res_take),
    .stat     (stat),
    .res      (res)
  );

  // output register takes a result once it is free or draining
  assign res_take = stat.done && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_res_r <= res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_read_value  = out_res_r.read_value;
  assign out_status      = out_res_r.status;
  assign out_is_empty    = out_res_r.is_empty;
  assign out_entry_count = out_res_r.entry_count;

endmodule

`default_nettype wire

// ===== tb/sv/stack_with_delete_by_value_tb.sv =====
// testbench for the stack with delete-by-value: directed table, then phased random operations
`default_nettype none

module stack_with_delete_by_value_tb;
  import swdv_pkg::*;

  localparam int DEPTH        = DEPTH_DEF;
  localparam int RANDOM_OPS   = 1030;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = 2 * DEPTH + 20;
  localparam int HOLD_AT      = 150;
  localparam int HOLD_CYCLES  = 300;
  localparam int MAX_LINES    = 40;

  // kinds of random phase
  localparam int PH_FILL   = 0;
  localparam int PH_DRAIN  = 1;
  localparam int PH_ANY    = 2;
  localparam int PH_DELETE = 3;

  // one directed row; expected fields count only when fixed is set
  typedef struct packed {
    logic [OP_W-1:0]      op;
    logic [DATA_W-1:0]    value;
    logic                 fixed;
    logic [DATA_W-1:0]    exp_value;
    logic [ST_W-1:0]      exp_status;
    logic                 exp_empty;
    logic [CNT_OUT_W-1:0] exp_count;
  } stim_row_t;

  localparam int DIRECTED_ROWS = 22;
  localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{OP_POP,    32'd0,         1'b1, 32'd0,         ST_EMPTY,     1'b1, 7'd0},
    '{OP_PEEK,   32'd0,         1'b1, 32'hFFFF_FFFF, ST_EMPTY,     1'b1, 7'd0},
    '{OP_DELETE, 32'd5,         1'b1, 32'd0,         ST_EMPTY,     1'b1, 7'd0},
    '{OP_PUSH,   32'h7FFF_FFFF, 1'b1, 32'd0,         ST_OK,        1'b0, 7'd1},
    '{OP_PUSH,   32'h8000_0000, 1'b1, 32'd0,         ST_OK,        1'b0, 7'd2},
    '{OP_PUSH,   32'd5,         1'b1, 32'd0,         ST_OK,        1'b0, 7'd3},
    '{OP_PUSH,   32'hFFFF_FFFF, 1'b1, 32'd0,         ST_OK,        1'b0, 7'd4},
    '{OP_PUSH,   32'd7,         1'b0, 32'd0,         ST_OK,        1'b0, 7'd0},
    '{OP_PUSH,   32'd5,         1'b0, 32'd0,         ST_OK,        1'b0, 7'd0},
    '{OP_PEEK,   32'hA5A5_5A5A, 1'b0, 32'd0,         ST_OK,        1'b0, 7'd0},
    '{OP_DELETE, 32'd123456,    1'b1, 32'd0,         ST_NOT_FOUND, 1'b0, 7'd6},
    '{OP_DELETE, 32'd5,         1'b0, 32'd0,         ST_OK,        1'b0, 7'd0},
    '{OP_PEEK,   32'd0,         1'b0, 32'd0,         ST_OK,        1'b0, 7'd0},
    '{OP_DELETE, 32'h8000_0000, 1'b0, 32'd0,         ST_OK,        1'b0, 7'd0},
    '{OP_DELETE, 32'h7FFF_FFFF, 1'b0, 32'd0,         ST_OK,        1'b0, 7'd0},
    '{OP_POP,    32'hFFFF_FFFF, 1'b0, 32'd0,         ST_OK,        1'b0, 7'd0},
    '{OP_POP,    32'd0,         1'b0, 32'd0,         ST_OK,        1'b0, 7'd0},
    '{OP_POP,    32'd0,         1'b0, 32'd0,         ST_OK,        1'b0, 7'd0},
    '{OP_POP,    32'd0,         1'b1, 32'd0,         ST_EMPTY,     1'b1, 7'd0},
    '{OP_PUSH,   32'd0,         1'b1, 32'd0,         ST_OK,        1'b0, 7'd1},
    '{OP_DELETE, 32'd0,         1'b0, 32'd0,         ST_OK,        1'b0, 7'd0},
    '{OP_PEEK,   32'd0,         1'b1, 32'hFFFF_FFFF, ST_EMPTY,     1'b1, 7'd0}
  };

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic [OP_W-1:0]       in_opcode;
  logic signed [DATA_W-1:0] in_value;
  logic                  out_valid;
  logic                  out_stall;
  logic signed [DATA_W-1:0] out_read_value;
  logic [ST_W-1:0]       out_status;
  logic                  out_is_empty;
  logic [CNT_OUT_W-1:0]  out_entry_count;

  // shadow stack and results still owed by the block
  logic [DATA_W-1:0] model_entries [DEPTH];
  int                model_fill = 0;
  swdv_res_t         pending_results [$];

  int error_count   = 0;
  int results_taken = 0;
  int cycle_count   = 0;
  bit send_gaps_on  = 1'b1;

  stack_with_delete_by_value #(.DEPTH(DEPTH)) u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_opcode       (in_opcode),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_read_value  (out_read_value),
    .out_status      (out_status),
    .out_is_empty    (out_is_empty),
    .out_entry_count (out_entry_count)
  );

  // clock and reset
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= MAX_LINES) begin
      $display("mismatch at cycle %0d: %s", cycle_count, msg);
    end
  endtask

  // apply one operation to the shadow stack and return its result
  function automatic swdv_res_t stack_apply(input logic [OP_W-1:0] op,
                                            input logic [DATA_W-1:0] value);
    swdv_res_t res;
    int        idx;
    int        j;
    res = '0;
    res.status = ST_OK;
    case (op)
      OP_PUSH: begin
        if (model_fill >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          model_entries[model_fill] = value;
          model_fill++;
        end
      end
      OP_POP: begin
        if (model_fill == 0) begin
          res.status = ST_EMPTY;
        end else begin
          model_fill--;
          res.read_value = model_entries[model_fill];
        end
      end
      OP_PEEK: begin
        if (model_fill == 0) begin
          res.read_value = -1;
          res.status = ST_EMPTY;
        end else begin
          res.read_value = model_entries[model_fill - 1];
        end
      end
      default: begin
        if (model_fill == 0) begin
          res.status = ST_EMPTY;
        end else begin
          // search from the top, then close the gap
          idx = model_fill - 1;
          while (idx >= 0 && model_entries[idx] != value) idx--;
          if (idx < 0) begin
            res.status = ST_NOT_FOUND;
          end else begin
            for (j = idx; j < model_fill - 1; j++) model_entries[j] = model_entries[j + 1];
            model_fill--;
          end
        end
      end
    endcase
    res.is_empty = (model_fill == 0);
    res.entry_count = CNT_OUT_W'(model_fill);
    return res;
  endfunction

  // offer one transaction, wait for it to be taken, then record what it should give
  task automatic send_op(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] value,
                         input bit use_fixed, input swdv_res_t fixed_res);
    int        gap;
    swdv_res_t predicted;
    gap = send_gaps_on ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_opcode <= op;
    in_value  <= value;
    do @(posedge clk); while (in_stall);
    predicted = stack_apply(op, value);
    pending_results.push_back(use_fixed ? fixed_res : predicted);
  endtask

  // stimulus
  initial begin
    stim_row_t         row;
    swdv_res_t         fixed_res;
    logic [OP_W-1:0]   op;
    logic [DATA_W-1:0] value;
    int                sent;
    int                phase_len;
    int                phase_kind;
    int                roll;
    int                pick;
    int                idx;
    in_valid  = 1'b0;
    in_opcode = OP_PUSH;
    in_value  = '0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);

    // directed table
    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      row = DIRECTED[r];
      fixed_res = {row.exp_value, row.exp_status, row.exp_empty, row.exp_count};
      send_op(row.op, row.value, row.fixed, fixed_res);
    end

    // random phases: fill, drain, anything, delete-heavy
    sent = 0;
    while (sent < RANDOM_OPS) begin
      phase_len = $urandom_range(20, 100);
      phase_kind = $urandom_range(PH_FILL, PH_DELETE);
      send_gaps_on = ($urandom_range(0, 3) != 0);
      for (int k = 0; k < phase_len && sent < RANDOM_OPS; k++) begin
        roll = $urandom_range(0, 99);
        case (phase_kind)
          PH_FILL:  op = roll < 88 ? OP_PUSH : roll < 92 ? OP_POP : roll < 96 ? OP_PEEK : OP_DELETE;
          PH_DRAIN: op = roll < 10 ? OP_PUSH : roll < 55 ? OP_POP : roll < 65 ? OP_PEEK : OP_DELETE;
          PH_ANY:   op = OP_W'($urandom_range(0, 3));
          default:  op = roll < 45 ? OP_PUSH : roll < 90 ? OP_DELETE : roll < 95 ? OP_POP : OP_PEEK;
        endcase
        value = $urandom;
        roll = $urandom_range(0, 9);
        if (op == OP_PUSH) begin
          // extremes and a small pool so that duplicates show up
          if (roll == 0) value = 32'h7FFF_FFFF;
          else if (roll == 1) value = 32'h8000_0000;
          else if (roll < 6) value = $urandom_range(0, 7);
        end else if (op == OP_DELETE) begin
          // mostly a value held now, often at the bottom or the top
          if (roll < 6 && model_fill > 0) begin
            pick = $urandom_range(0, 3);
            idx = pick == 0 ? 0 : pick == 1 ? model_fill - 1 : $urandom_range(0, model_fill - 1);
            value = model_entries[idx];
          end else if (roll < 8) begin
            value = $urandom_range(0, 7);
          end
        end
        send_op(op, value, 1'b0, '0);
        sent++;
      end
    end
    in_valid <= 1'b0;

    // let every owed result arrive, then watch for strays
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // result side: random stalls, one long hold, and the check of each transaction
  initial begin
    int        hold;
    bit        stall_on;
    swdv_res_t exp_res;
    out_stall = 1'b0;
    stall_on = 1'b1;
    forever begin
      if (results_taken % 40 == 0) stall_on = ($urandom_range(0, 2) != 0);
      hold = stall_on ? $urandom_range(0, 7) : 0;
      if (results_taken == HOLD_AT) hold = HOLD_CYCLES;
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(rst_n && out_valid && !out_stall));
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing expected");
      end else begin
        exp_res = pending_results.pop_front();
        if (out_read_value !== exp_res.read_value)
          report_mismatch($sformatf("read_value got %0d expected %0d",
                                    out_read_value, exp_res.read_value));
        if (out_status !== exp_res.status)
          report_mismatch($sformatf("status got %0d expected %0d", out_status, exp_res.status));
        if (out_is_empty !== exp_res.is_empty)
          report_mismatch($sformatf("is_empty got %0b expected %0b",
                                    out_is_empty, exp_res.is_empty));
        if (out_entry_count !== exp_res.entry_count)
          report_mismatch($sformatf("entry_count got %0d expected %0d",
                                    out_entry_count, exp_res.entry_count));
      end
      results_taken++;
    end
  end

endmodule

`default_nettype wire
